/* rtl/core/rls_pkg.sv */
// rls_pkg: shared types and constants of the rgb led strip serializer
// no dependencies; imported by rls_cfg_regs, rls_frame_ctrl, the top level and the testbench

package rls_pkg;

  // pixel store geometry
  localparam int unsigned PIX_DEPTH = 256;
  localparam int unsigned LED_AW   = 8;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned BIT_W    = 5;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 9;

  // last bit of a grb word, counted from the msb
  localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_LED_COUNT = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ZERO_HIGH = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ZERO_LOW  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_ONE_HIGH  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_ONE_LOW   = 3'd4;

  // request opcodes
  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_REFRESH   = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  // raw configuration register contents
  typedef struct packed {
    logic [CNT_W-1:0]  led_count;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic    line_level;
    logic    busy_res;
    logic    frame_done;
    status_e status;
  } res_t;

endpackage

/* rtl/core/rls_in_if.sv */
// rls_in_if: request channel of the rgb led strip serializer
// depends on nothing; valid/ready handshake with the request payload

interface rls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output op, output index, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input op, input index, input red, input green,
                  input blue, output ready);
endinterface

/* rtl/core/rls_out_if.sv */
// rls_out_if: result channel of the rgb led strip serializer
// depends on nothing; valid/ready handshake with the result payload

interface rls_out_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       busy_res;
  logic       frame_done;
  logic [1:0] status;

  modport source (output valid, output line_level, output busy_res, output frame_done,
                  output status, input ready);
  modport sink   (input valid, input line_level, input busy_res, input frame_done,
                  input status, output ready);
endinterface

/* rtl/core/rls_ram.sv */
// rls_ram: generic single write port, single read port ram with registered read
// no dependencies

module rls_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rls_cfg_regs.sv */
// rls_cfg_regs: timing and led count configuration registers
// depends on rls_pkg for register indexes and the cfg_t struct

module rls_cfg_regs
  import rls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [CFG_AW-1:0] idx_i,
  input  logic [CFG_DW-1:0] wdata_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_LED_COUNT: cfg_d.led_count = wdata_i;
        CFG_ZERO_HIGH: cfg_d.zero_high = wdata_i[TICK_W-1:0];
        CFG_ZERO_LOW:  cfg_d.zero_low  = wdata_i[TICK_W-1:0];
        CFG_ONE_HIGH:  cfg_d.one_high  = wdata_i[TICK_W-1:0];
        CFG_ONE_LOW:   cfg_d.one_low   = wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_count <= 9'd256;
      cfg_q.zero_high <= 8'd4;
      cfg_q.zero_low  <= 8'd8;
      cfg_q.one_high  <= 8'd8;
      cfg_q.one_low   <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/rls_frame_ctrl.sv */
// rls_frame_ctrl: pixel store and frame sequencer, one request per cycle
// depends on rls_pkg and rls_ram; produces the result of each accepted request

module rls_frame_ctrl
  import rls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        req_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output res_t        res_o
);

  // frame state
  logic              sending_q, sending_d;
  logic [LED_AW-1:0] led_pos_q, led_pos_d;
  logic [BIT_W-1:0]  bit_pos_q, bit_pos_d;
  logic              low_q, low_d;
  logic [TICK_W-1:0] phase_q, phase_d;
  logic [PIX_W-1:0]  cur_word_q, cur_word_d;
  logic [PIX_W-1:0]  pix0_q;

  // pixel store valid bits, cleared at reset
  logic              valid_q [PIX_DEPTH];
  logic              rd_valid_q;

  logic              ram_we;
  logic [PIX_W-1:0]  wr_word;
  logic [LED_AW-1:0] rd_addr;
  logic [PIX_W-1:0]  ram_rdata;
  logic [PIX_W-1:0]  next_word;

  logic [CNT_W-1:0]  eff_cnt;
  logic              idx_ok;
  logic              cur_bit;
  logic [TICK_W-1:0] dur_raw;
  logic [TICK_W-1:0] dur;
  logic [TICK_W-1:0] phase_inc;
  logic              phase_end;
  logic              led_last;

  assign wr_word = {green_i, red_i, blue_i};
  // prefetch the next led while the current one is shifted out
  assign rd_addr = led_pos_q + 8'd1;

  rls_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (index_i),
    .wdata_i (wr_word),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign next_word = rd_valid_q ? ram_rdata : '0;

  // effective count and bit timing
  always_comb begin
    if (cfg_i.led_count == '0) begin
      eff_cnt = 9'd1;
    end else if (cfg_i.led_count > CNT_W'(PIX_DEPTH)) begin
      eff_cnt = CNT_W'(PIX_DEPTH);
    end else begin
      eff_cnt = cfg_i.led_count;
    end
    idx_ok    = {1'b0, index_i} < eff_cnt;
    cur_bit   = cur_word_q[LAST_BIT - bit_pos_q];
    if (low_q) begin
      dur_raw = cur_bit ? cfg_i.one_low : cfg_i.zero_low;
    end else begin
      dur_raw = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
    end
    dur       = (dur_raw == '0) ? 8'd1 : dur_raw;
    phase_inc = phase_q + 8'd1;
    phase_end = (phase_inc >= dur) || (phase_inc == '0);
    led_last  = ({1'b0, led_pos_q} + 9'd1) >= eff_cnt;
  end

  // request decode and next state
  always_comb begin
    sending_d  = sending_q;
    led_pos_d  = led_pos_q;
    bit_pos_d  = bit_pos_q;
    low_d      = low_q;
    phase_d    = phase_q;
    cur_word_d = cur_word_q;
    ram_we     = 1'b0;
    res_o.line_level = 1'b0;
    res_o.frame_done = 1'b0;
    res_o.status     = ST_OK;
    case (op_i)
      OP_SET_PIXEL: begin
        if (sending_q) begin
          res_o.status = ST_BUSY;
        end else if (!idx_ok) begin
          res_o.status = ST_RANGE;
        end else begin
          ram_we = req_i;
        end
      end
      OP_REFRESH: begin
        if (sending_q) begin
          res_o.status = ST_BUSY;
        end else begin
          sending_d  = 1'b1;
          led_pos_d  = '0;
          bit_pos_d  = '0;
          low_d      = 1'b0;
          phase_d    = '0;
          cur_word_d = pix0_q;
        end
      end
      OP_TICK: begin
        if (sending_q) begin
          res_o.line_level = !low_q;
          phase_d = phase_inc;
          if (phase_end) begin
            phase_d = '0;
            if (!low_q) begin
              low_d = 1'b1;
            end else begin
              low_d = 1'b0;
              if (bit_pos_q >= LAST_BIT) begin
                bit_pos_d = '0;
                if (led_last) begin
                  led_pos_d        = '0;
                  sending_d        = 1'b0;
                  res_o.frame_done = 1'b1;
                end else begin
                  led_pos_d  = led_pos_q + 8'd1;
                  cur_word_d = next_word;
                end
              end else begin
                bit_pos_d = bit_pos_q + 5'd1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res_o.busy_res = sending_d;
  end

  // frame state registers, updated on an accepted request only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q  <= 1'b0;
      led_pos_q  <= '0;
      bit_pos_q  <= '0;
      low_q      <= 1'b0;
      phase_q    <= '0;
      cur_word_q <= '0;
      pix0_q     <= '0;
    end else if (req_i) begin
      sending_q  <= sending_d;
      led_pos_q  <= led_pos_d;
      bit_pos_q  <= bit_pos_d;
      low_q      <= low_d;
      phase_q    <= phase_d;
      cur_word_q <= cur_word_d;
      if (ram_we && (index_i == '0)) begin
        pix0_q <= wr_word;
      end
    end
  end

  // valid bits and registered valid of the prefetch read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIX_DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
      rd_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[index_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // an idle sequencer always rests at the start of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (led_pos_q == '0) && (bit_pos_q == '0) && !low_q && (phase_q == '0))
    else $error("idle sequencer not parked at frame start");

  // bit position never leaves the 24-bit word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= LAST_BIT)
    else $error("bit position beyond last bit");

  // the pixel store is frozen while a frame is shifted out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !sending_q)
    else $error("pixel store written during a frame");

endmodule

/* rtl/core/rgb_led_strip_serializer.sv */
// rgb_led_strip_serializer: single-wire rgb led strip driver, top level
// depends on rls_pkg, rls_in_if, rls_out_if, rls_cfg_regs and rls_frame_ctrl
// result: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle while the result register is free or draining
// reset: clears frame state, config to 256/4/8/8/4; pixel store reads zero via valid bits

module rgb_led_strip_serializer
  import rls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  rls_in_if.sink            in_i,
  rls_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic accept;

  // request accepted whenever the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  rls_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  rls_frame_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .req_i   (accept),
    .op_i    (in_i.op),
    .index_i (in_i.index),
    .red_i   (in_i.red),
    .green_i (in_i.green),
    .blue_i  (in_i.blue),
    .res_o   (res)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.line_level = res_q.line_level;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.frame_done = res_q.frame_done;
  assign out_o.status     = res_q.status;

  // the tick that ends a frame leaves the driver idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |-> !res_q.busy_res)
    else $error("frame done reported while still busy");

  // a rejected or out of range request never drives the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status != ST_OK) |-> !res_q.line_level && !res_q.frame_done)
    else $error("rejected request produced line activity");

  // a high line phase never ends a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.line_level |-> res_q.busy_res)
    else $error("high line level with the frame already over");

endmodule

/* sim/rgb_led_strip_serializer_test.sv */
// rgb_led_strip_serializer_test: self-checking testbench of the led strip serializer
// drives requests, configuration and result stalls; a scoreboard class predicts each result
// depends on rls_pkg, rls_in_if, rls_out_if and rgb_led_strip_serializer

module rgb_led_strip_serializer_test;
  import rls_pkg::*;

  // op code that the block treats as no operation
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned MAX_REPORTS = 200;

  // predicts the serializer and checks its results in order
  class strip_scoreboard;
    logic [PIX_W-1:0]  pixels [PIX_DEPTH];
    logic [LED_AW-1:0] led_pos;
    logic [BIT_W-1:0]  bit_pos;
    logic              low_phase;
    logic [TICK_W-1:0] phase_cnt;
    logic              sending;
    cfg_t              regs;
    res_t              expected_q [$];
    int unsigned       errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      led_pos        = '0;
      bit_pos        = '0;
      low_phase      = 1'b0;
      phase_cnt      = '0;
      sending        = 1'b0;
      regs.led_count = 9'd256;
      regs.zero_high = 8'd4;
      regs.zero_low  = 8'd8;
      regs.one_high  = 8'd8;
      regs.one_low   = 8'd4;
      errors         = 0;
    endfunction

    // led count as used, clamped to 1..PIX_DEPTH
    function int unsigned active_leds();
      if (regs.led_count == 0) return 1;
      if (regs.led_count > PIX_DEPTH) return PIX_DEPTH;
      return regs.led_count;
    endfunction

    function int unsigned phase_len(logic [TICK_W-1:0] v);
      return (v == 0) ? 1 : v;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_LED_COUNT: regs.led_count = data;
        CFG_ZERO_HIGH: regs.zero_high = data[TICK_W-1:0];
        CFG_ZERO_LOW:  regs.zero_low  = data[TICK_W-1:0];
        CFG_ONE_HIGH:  regs.one_high  = data[TICK_W-1:0];
        CFG_ONE_LOW:   regs.one_low   = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the model by one accepted request and queue its result
    function void note_request(logic [1:0] op, logic [7:0] index, logic [7:0] red,
                               logic [7:0] green, logic [7:0] blue);
      res_t             want;
      logic [PIX_W-1:0] word;
      logic             one;
      int unsigned      dur;
      want        = '0;
      want.status = ST_OK;
      case (op)
        OP_SET_PIXEL: begin
          if (sending) want.status = ST_BUSY;
          else if (index >= active_leds()) want.status = ST_RANGE;
          else pixels[index] = {green, red, blue};
        end
        OP_REFRESH: begin
          if (sending) begin
            want.status = ST_BUSY;
          end else begin
            sending   = 1'b1;
            led_pos   = '0;
            bit_pos   = '0;
            low_phase = 1'b0;
            phase_cnt = '0;
          end
        end
        OP_TICK: begin
          if (sending) begin
            word = pixels[led_pos];
            one  = word[LAST_BIT - bit_pos];
            if (low_phase) dur = phase_len(one ? regs.one_low : regs.zero_low);
            else dur = phase_len(one ? regs.one_high : regs.zero_high);
            want.line_level = ~low_phase;
            phase_cnt = phase_cnt + 1'b1;
            // phase over: high goes to low, low moves to the next bit
            if (phase_cnt >= dur || phase_cnt == 0) begin
              phase_cnt = '0;
              if (!low_phase) begin
                low_phase = 1'b1;
              end else begin
                low_phase = 1'b0;
                if (bit_pos >= LAST_BIT) begin
                  bit_pos = '0;
                  if (int'(led_pos) + 1 >= active_leds()) begin
                    led_pos         = '0;
                    sending         = 1'b0;
                    want.frame_done = 1'b1;
                  end else begin
                    led_pos++;
                  end
                end else begin
                  bit_pos++;
                end
              end
            end
          end
        end
        default: ;
      endcase
      want.busy_res = sending;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [1:0] want_v, logic [1:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic line, logic busy, logic done, logic [1:0] st);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected result: expected none actual line=%b busy=%b done=%b st=%0d",
                   $time, line, busy, done, st);
        return;
      end
      want = expected_q.pop_front();
      compare_field("line_level", want.line_level, line);
      compare_field("busy_res", want.busy_res, busy);
      compare_field("frame_done", want.frame_done, done);
      compare_field("status", want.status, st);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              hold_off;
  int unsigned       gap_pct;
  int unsigned       stall_pct;
  int unsigned       items_sent;
  strip_scoreboard   sb;

  rls_in_if  req_if ();
  rls_out_if res_if ();

  rgb_led_strip_serializer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // result side stalls, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.line_level, res_if.busy_res, res_if.frame_done, res_if.status);
  end

  function automatic logic [7:0] short_len();
    return 8'($urandom_range(3));
  endfunction

  // offer one request after a random gap and wait for it to be taken
  task automatic send_item(logic [1:0] op, logic [7:0] index, logic [7:0] red,
                           logic [7:0] green, logic [7:0] blue);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.index <= index;
    req_if.red   <= red;
    req_if.green <= green;
    req_if.blue  <= blue;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(op, index, red, green, blue);
    items_sent++;
  endtask

  task automatic send_pixel(logic [7:0] index, logic [7:0] red, logic [7:0] green,
                            logic [7:0] blue);
    send_item(OP_SET_PIXEL, index, red, green, blue);
  endtask

  // any op with random payload bits
  task automatic send_op(logic [1:0] op);
    send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // write all five registers on consecutive cycles
  task automatic write_regs(logic [CFG_DW-1:0] led_cnt, logic [7:0] zh, logic [7:0] zl,
                            logic [7:0] oh, logic [7:0] ol);
    logic [CFG_AW-1:0] idx_list [5];
    logic [CFG_DW-1:0] val_list [5];
    idx_list = '{CFG_LED_COUNT, CFG_ZERO_HIGH, CFG_ZERO_LOW, CFG_ONE_HIGH, CFG_ONE_LOW};
    val_list = '{led_cnt, {1'b0, zh}, {1'b0, zl}, {1'b0, oh}, {1'b0, ol}};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[i];
      cfg_wdata <= val_list[i];
      @(posedge clk_i);
      sb.write_reg(idx_list[i], val_list[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // ticks while a frame runs, with some other requests mixed in
  task automatic run_frame(int unsigned max_ticks, int unsigned noise_pct);
    int unsigned n;
    int unsigned pick;
    n = 0;
    while (sb.sending && n < max_ticks) begin
      if ($urandom_range(99) < noise_pct) begin
        pick = $urandom_range(2);
        if (pick == 0) send_op(OP_SET_PIXEL);
        else if (pick == 1) send_op(OP_REFRESH);
        else send_op(OP_UNUSED);
      end else begin
        send_op(OP_TICK);
      end
      n++;
    end
  endtask

  // set some pixels, refresh, then tick the frame out (sometimes cut short)
  task automatic frame_sequence();
    int unsigned led_cnt;
    int unsigned nset;
    bit          cut;
    if ($urandom_range(1)) run_frame(20000, 0);
    led_cnt = sb.active_leds();
    nset = $urandom_range(0, (led_cnt < 4) ? led_cnt + 1 : 5);
    repeat (nset)
      send_pixel(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(led_cnt - 1)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    send_op(OP_REFRESH);
    cut = ($urandom_range(9) == 0);
    run_frame(cut ? $urandom_range(1, 40) : 20000, 5);
  endtask

  // one setting of registers and idling, then two rounds of frame sequences or random ops
  task automatic run_phase(int unsigned phase);
    int unsigned r;
    logic [CFG_DW-1:0] led_cnt;
    drain();
    r = $urandom_range(99);
    if (r < 10) led_cnt = '0;
    else led_cnt = CFG_DW'($urandom_range(1, 4));
    write_regs(led_cnt, short_len(), short_len(), short_len(), short_len());
    case (phase % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 85; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 85; end
      default: begin gap_pct = 37; stall_pct = 37; end
    endcase
    // long result hold-off while requests keep coming
    if (phase == 0) begin
      fork
        begin
          hold_off <= 1'b1;
          repeat (300) @(posedge clk_i);
          hold_off <= 1'b0;
        end
      join_none
    end
    repeat (2) begin
      if ($urandom_range(99) < 75) frame_sequence();
      else repeat ($urandom_range(4, 12)) send_op(2'($urandom_range(3)));
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned start_items;
    int unsigned wait_cycles;
    sb          = new();
    hold_off    = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    items_sent  = 0;
    req_if.valid <= 1'b0;
    req_if.op    <= OP_TICK;
    req_if.index <= '0;
    req_if.red   <= '0;
    req_if.green <= '0;
    req_if.blue  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_LED_COUNT;
    cfg_wdata    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, unused op, corner pixels at the full led count
    send_op(OP_TICK);
    send_op(OP_UNUSED);
    send_pixel(8'd0, 8'hff, 8'hff, 8'hff);
    send_pixel(8'd255, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd128, 8'h5a, 8'ha5, 8'h3c);
    drain();

    // zero led count and zero phase lengths clamp to one
    write_regs('0, '0, '0, '0, '0);
    send_pixel(8'd1, 8'h12, 8'h34, 8'h56);
    send_pixel(8'd255, 8'hff, 8'hff, 8'hff);
    send_pixel(8'd0, 8'h01, 8'h80, 8'hfe);
    send_op(OP_REFRESH);
    // busy rejections, busy wins over a bad index
    send_pixel(8'd0, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd200, 8'hff, 8'h00, 8'hff);
    send_op(OP_REFRESH);
    send_op(OP_UNUSED);
    repeat (12) send_op(OP_TICK);

    // random phases, every idling mode at least once; the first changes registers mid-frame
    start_items = items_sent;
    phase = 0;
    while (items_sent - start_items < RANDOM_ITEMS || phase < 4) begin
      run_phase(phase);
      phase++;
    end

    // led count above the maximum, shortest phases, start of a frame
    drain();
    gap_pct   = 0;
    stall_pct = 0;
    write_regs(9'h1ff, '0, '0, '0, '0);
    send_pixel(8'd255, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    send_op(OP_REFRESH);
    run_frame(100, 0);

    // longest phases on a single led, switched in while the frame runs
    drain();
    write_regs(9'd1, 8'hff, 8'hff, 8'hff, 8'hff);
    send_op(OP_SET_PIXEL);
    send_op(OP_REFRESH);
    run_frame(300, 0);

    // wait for the last results
    req_if.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending() != 0)
        $display("%0t %0d expected results never arrived", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
